// File: src/gate_opener_controller_macros.svh
// Assertion helpers for the gate opener controller.
`ifndef GATE_OPENER_CONTROLLER_MACROS_SVH
`define GATE_OPENER_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define GOC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gate opener controller: check failed");
`define GOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gate opener controller: sequence check failed");
`else
`define GOC_ASSERT(label, clk, rst, prop)
`define GOC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: src/goc_pkg.sv
package goc_pkg;

  localparam int unsigned CountWidth = 16;
  localparam logic [CountWidth-1:0] TimeoutReset = 16'd3600;

  typedef enum logic [2:0] {
    ST_INIT    = 3'd0,
    ST_CLOSING = 3'd1,
    ST_OPENING = 3'd2,
    ST_OPEN    = 3'd3,
    ST_CLOSED  = 3'd4,
    ST_STOPPED = 3'd5,
    ST_ERROR   = 3'd6
  } gate_state_t;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_BOTH    = 2'd1,
    FAULT_TIMEOUT = 2'd2
  } fault_t;

  typedef enum logic [1:0] {
    LAMP_OFF     = 2'd0,
    LAMP_ERROR   = 2'd1,
    LAMP_MOVING  = 2'd2,
    LAMP_STOPPED = 2'd3
  } lamp_t;

  typedef struct packed {
    logic open_limit;
    logic closed_limit;
    logic photocell;
    logic push_button;
    logic open_command;
  } tick_t;

  typedef struct packed {
    logic        motor_open;
    logic        motor_close;
    lamp_t       lamp_mode;
    gate_state_t gate_state;
    fault_t      fault_code;
  } result_t;

  // Controller state carried from one tick to the next
  typedef struct packed {
    gate_state_t           state;
    logic [CountWidth-1:0] count;
    fault_t                fault;
  } ctrl_t;

endpackage

// File: src/goc_tick_if.sv
interface goc_tick_if;
  logic           valid;
  logic           ready;
  goc_pkg::tick_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/goc_result_if.sv
interface goc_result_if;
  logic             valid;
  logic             ready;
  goc_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/goc_step.sv
module goc_step (
  input  goc_pkg::ctrl_t                       cur,
  input  logic [goc_pkg::CountWidth-1:0]       timeout,
  input  goc_pkg::tick_t                       tick,
  output goc_pkg::ctrl_t                       nxt
);
  import goc_pkg::*;

  logic [CountWidth-1:0] cnt_inc;
  logic                  over;
  logic                  both;

  always_comb begin
    // saturating tick counter
    cnt_inc = (cur.count == '1) ? cur.count : cur.count + CountWidth'(1);
    over    = cnt_inc > timeout;
    both    = tick.open_limit & tick.closed_limit;
    nxt     = cur;

    unique case (cur.state)
      ST_CLOSING: begin
        nxt.count = cnt_inc;
        if (both) begin
          nxt.state = ST_ERROR;
          nxt.fault = FAULT_BOTH;
        end else if (tick.photocell) begin
          nxt.state = ST_OPENING;
        end else if (tick.closed_limit) begin
          nxt.state = ST_CLOSED;
        end else if (over) begin
          nxt.state = ST_ERROR;
          nxt.fault = FAULT_TIMEOUT;
        end
      end
      ST_OPENING: begin
        nxt.count = cnt_inc;
        if (both) begin
          nxt.state = ST_ERROR;
          nxt.fault = FAULT_BOTH;
        end else if (tick.open_limit) begin
          nxt.state = ST_OPEN;
        end else if (tick.push_button) begin
          nxt.state = ST_STOPPED;
        end else if (over) begin
          nxt.state = ST_ERROR;
          nxt.fault = FAULT_TIMEOUT;
        end
      end
      ST_OPEN: begin
        nxt.count = cnt_inc;
        if (tick.photocell) begin
          // obstacle holds the gate open and restarts the timer
          nxt.count = '0;
        end else if (tick.push_button || tick.open_command) begin
          nxt.state = ST_CLOSING;
        end else if (both) begin
          nxt.state = ST_ERROR;
          nxt.fault = FAULT_BOTH;
        end else if (over) begin
          nxt.state = ST_ERROR;
          nxt.fault = FAULT_TIMEOUT;
        end
      end
      ST_CLOSED: begin
        if (tick.push_button || tick.open_command) begin
          nxt.state = ST_OPENING;
        end else if (!tick.open_limit && !tick.closed_limit) begin
          nxt.state = ST_CLOSING;
        end else if (both) begin
          nxt.state = ST_ERROR;
          nxt.fault = FAULT_BOTH;
        end
      end
      ST_STOPPED: begin
        if (tick.push_button && !tick.closed_limit) begin
          nxt.state = ST_CLOSING;
        end else if (tick.open_limit && !tick.photocell) begin
          nxt.state = ST_OPENING;
        end else if (both) begin
          nxt.state = ST_ERROR;
          nxt.fault = FAULT_BOTH;
        end
      end
      ST_ERROR: begin
        // limit fault recovers once cleared; timeout holds until reset
        if (cur.fault == FAULT_BOTH && !both) begin
          nxt.state = ST_INIT;
        end
      end
      default: begin
        // init, and the unused code
        nxt.fault = FAULT_NONE;
        nxt.count = '0;
        if (both) begin
          nxt.state = ST_ERROR;
          nxt.fault = FAULT_BOTH;
        end else if (!tick.open_limit && !tick.closed_limit) begin
          nxt.state = ST_CLOSING;
        end else if (tick.closed_limit) begin
          nxt.state = ST_CLOSED;
        end else begin
          nxt.state = ST_OPEN;
        end
      end
    endcase

    if (nxt.state != cur.state) begin
      if (nxt.state == ST_CLOSING || nxt.state == ST_OPENING || nxt.state == ST_OPEN) begin
        nxt.count = '0;
      end
      if (nxt.state == ST_INIT) begin
        nxt.fault = FAULT_NONE;
      end
    end
  end

endmodule

// File: src/gate_opener_controller.sv
// Channel   Dir  Payload                                          Handshake
// tick      in   open/closed limit, photocell, button, command    valid/ready
// result    out  motor open/close, lamp, gate state, fault code   valid/ready
// cfg_wr_*  in   timeout_ticks (16 bit)                           write enable
//
// One tick per clock while tick.ready is high: the next state is computed
// from the incoming tick and registered together with its result in the
// same cycle. A two-entry output buffer (result register plus skid) keeps
// ticks flowing while the result side stalls; tick.ready drops only when
// both entries are full. Synchronous reset returns the controller to init
// with the timeout at 3600 ticks and empties the output buffer.
module gate_opener_controller (
  input  logic                           clk,
  input  logic                           rst,
  goc_tick_if.sink                       tick,
  goc_result_if.source                   result,
  input  logic                           cfg_wr_en,
  input  logic [goc_pkg::CountWidth-1:0] cfg_wr_data
);
  import goc_pkg::*;
  `include "gate_opener_controller_macros.svh"

  logic [CountWidth-1:0] timeout;
  ctrl_t                 ctrl;
  ctrl_t                 ctrl_next;
  result_t               res_next;
  logic                  out_valid;
  result_t               out_data;
  logic                  skid_valid;
  result_t               skid_data;
  logic                  accept;
  logic                  taken;
  logic                  in_error;
  logic                  fault_set;
  logic                  timeout_latched;

  goc_step u_step (
    .cur     (ctrl),
    .timeout (timeout),
    .tick    (tick.data),
    .nxt     (ctrl_next)
  );

  always_comb begin
    res_next             = '0;
    res_next.motor_open  = (ctrl_next.state == ST_OPENING);
    res_next.motor_close = (ctrl_next.state == ST_CLOSING);
    res_next.gate_state  = ctrl_next.state;
    res_next.fault_code  = ctrl_next.fault;
    case (ctrl_next.state)
      ST_CLOSING, ST_OPENING: res_next.lamp_mode = LAMP_MOVING;
      ST_STOPPED:             res_next.lamp_mode = LAMP_STOPPED;
      ST_ERROR:               res_next.lamp_mode = LAMP_ERROR;
      default:                res_next.lamp_mode = LAMP_OFF;
    endcase
  end

  assign tick.ready   = !skid_valid;
  assign accept       = tick.valid && tick.ready;
  assign taken        = out_valid && result.ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  assign in_error        = (ctrl.state == ST_ERROR);
  assign fault_set       = (ctrl.fault != FAULT_NONE);
  assign timeout_latched = in_error && (ctrl.fault == FAULT_TIMEOUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout    <= TimeoutReset;
      ctrl       <= '{state: ST_INIT, count: '0, fault: FAULT_NONE};
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      if (accept) begin
        ctrl <= ctrl_next;
        // skid is empty whenever a transaction is accepted
        if (!out_valid || taken) begin
          out_valid <= 1'b1;
          out_data  <= res_next;
        end else begin
          skid_valid <= 1'b1;
          skid_data  <= res_next;
        end
      end else if (taken) begin
        out_valid  <= skid_valid;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end
  end

  `GOC_ASSERT(a_skid_behind_out, clk, rst, (!skid_valid || out_valid))
  `GOC_ASSERT(a_fault_only_in_error, clk, rst, (fault_set == in_error))
  `GOC_ASSERT(a_motor_exclusive, clk, rst, (!(out_valid && out_data.motor_open && out_data.motor_close)))
  `GOC_ASSERT_NEXT(a_timeout_sticks, clk, rst, timeout_latched, timeout_latched)

endmodule
